@@ src/bounded_indexed_list_assert.svh @@
// ----------------------------------------------------------------------------
// bounded_indexed_list_assert.svh
// assertion macros shared by the list block, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INDEXED_LIST_ASSERT_SVH
`define BOUNDED_INDEXED_LIST_ASSERT_SVH

// same-cycle implication
`define BIL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bil_pkg.sv @@
// ----------------------------------------------------------------------------
// bil_pkg
// types and codes shared by the bounded indexed list modules
// ----------------------------------------------------------------------------
package bil_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_READ       = 3'd6,
        MODE_CLEAR      = 3'd7
    } bil_mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } bil_status_t;

    typedef struct packed {
        bil_mode_t                 mode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } bil_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic [CNT_W-1:0]          count;
        bil_status_t               status;
    } bil_rsp_t;

    // logical index used for a memory read
    typedef enum logic [2:0] {
        RD_FRONT = 3'd0,
        RD_BACK  = 3'd1,
        RD_POS   = 3'd2,
        RD_NEXT  = 3'd3,
        RD_PRIOR = 3'd4
    } bil_rd_sel_t;

    // destination of a memory write
    typedef enum logic [2:0] {
        WR_HEAD_DEC = 3'd0,
        WR_LEN      = 3'd1,
        WR_POS      = 3'd2,
        WR_NEXT     = 3'd3,
        WR_PRIOR    = 3'd4
    } bil_wr_sel_t;

    typedef struct packed {
        logic        cap_req;
        logic        clr_data;
        logic        rd_en;
        bil_rd_sel_t rd_sel;
        logic        wr_en;
        bil_wr_sel_t wr_sel;
        logic        wr_ram;
        logic        cap_data;
        logic        finish;
    } bil_cmd_t;

    typedef struct packed {
        bil_mode_t   mode;
        logic        err;
        logic        pos_is_len;
        logic        prev_is_pos;
        logic        prev_is_last;
        logic        out_free;
    } bil_stat_t;

endpackage

@@ src/bil_ram.sv @@
// ----------------------------------------------------------------------------
// bil_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bil_ctrl.sv @@
// ----------------------------------------------------------------------------
// bil_ctrl
// request sequencer: decides reads, writes and the copy loop for each item
// ----------------------------------------------------------------------------
module bil_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bil_pkg::bil_stat_t stat,
    output bil_pkg::bil_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_READ   = 6'b000100,
        S_MOVE   = 6'b001000,
        S_PLACE  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.clr_data = 1'b1;
                state_next   = S_FINISH;
                if (!stat.err)
                begin
                    case (stat.mode) inside
                        bil_pkg::MODE_PUSH_FRONT:
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = bil_pkg::WR_HEAD_DEC;
                        end
                        bil_pkg::MODE_PUSH_BACK:
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = bil_pkg::WR_LEN;
                        end
                        bil_pkg::MODE_POP_FRONT:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bil_pkg::RD_FRONT;
                            state_next = S_READ;
                        end
                        bil_pkg::MODE_POP_BACK:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bil_pkg::RD_BACK;
                            state_next = S_READ;
                        end
                        bil_pkg::MODE_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bil_pkg::RD_POS;
                            state_next = S_READ;
                        end
                        bil_pkg::MODE_INSERT:
                        begin
                            if (stat.pos_is_len)
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = bil_pkg::WR_POS;
                            end
                            else
                            begin
                                // shift the tail up, starting at the last entry
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = bil_pkg::RD_BACK;
                                state_next = S_MOVE;
                            end
                        end
                        bil_pkg::MODE_REMOVE:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bil_pkg::RD_POS;
                            state_next = S_MOVE;
                        end
                        default:
                        begin
                            // clear touches only the length
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.cap_data = 1'b1;
                state_next   = S_FINISH;
            end
            S_MOVE:
            begin
                if (stat.mode == bil_pkg::MODE_INSERT)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_ram = 1'b1;
                    cmd.wr_sel = bil_pkg::WR_NEXT;
                    if (stat.prev_is_pos)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = bil_pkg::RD_PRIOR;
                    end
                end
                else
                begin
                    if (stat.prev_is_pos)
                    begin
                        cmd.cap_data = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_ram = 1'b1;
                        cmd.wr_sel = bil_pkg::WR_PRIOR;
                    end
                    if (stat.prev_is_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = bil_pkg::RD_NEXT;
                    end
                end
            end
            S_PLACE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bil_pkg::WR_POS;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/bil_dp.sv @@
// ----------------------------------------------------------------------------
// bil_dp
// list datapath: circular store, head and length, status and result register
// ----------------------------------------------------------------------------
`include "bounded_indexed_list_assert.svh"

module bil_dp #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bil_pkg::bil_req_t  req,
    input  bil_pkg::bil_cmd_t  cmd,
    output bil_pkg::bil_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bil_pkg::bil_rsp_t  rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LEN_W > bil_pkg::POS_W) ? LEN_W : bil_pkg::POS_W;

    bil_pkg::bil_req_t               req_reg;
    logic [AW-1:0]                   head_reg;
    logic [AW-1:0]                   head_next;
    logic [LEN_W-1:0]                length_reg;
    logic [LEN_W-1:0]                length_next;
    logic [AW-1:0]                   prev_reg;
    logic signed [bil_pkg::DATA_W-1:0] data_reg;
    bil_pkg::bil_rsp_t               rsp_reg;
    logic                            rsp_valid_reg;

    logic [CMP_W-1:0]                len_cmp;
    logic [CMP_W-1:0]                pos_cmp;
    logic [CMP_W-1:0]                new_len_cmp;
    logic [LEN_W-1:0]                len_dec;
    logic [AW-1:0]                   pos_idx;
    logic [AW-1:0]                   len_idx;
    logic [AW-1:0]                   back_idx;
    logic [AW-1:0]                   head_dec;
    logic [AW-1:0]                   head_inc;
    logic                            is_full;
    logic                            is_empty;
    bil_pkg::bil_status_t            status;
    logic [AW-1:0]                   rd_idx;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   wr_idx;
    logic [AW-1:0]                   wr_addr;
    logic [bil_pkg::DATA_W-1:0]      wr_data;
    logic [bil_pkg::DATA_W-1:0]      ram_rdata;

    // logical index to slot, wrapping around the circular store
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                 input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign len_cmp  = CMP_W'(length_reg);
    assign pos_cmp  = CMP_W'(req_reg.position);
    assign len_dec  = length_reg - LEN_W'(1);
    assign pos_idx  = pos_cmp[AW-1:0];
    assign len_idx  = length_reg[AW-1:0];
    assign back_idx = len_dec[AW-1:0];
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign is_full  = (length_reg == LEN_W'(DEPTH));
    assign is_empty = (length_reg == '0);

    always_comb
    begin
        status = bil_pkg::ST_OK;
        unique case (req_reg.mode) inside
            bil_pkg::MODE_PUSH_FRONT, bil_pkg::MODE_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = bil_pkg::ST_FULL;
                end
            end
            bil_pkg::MODE_POP_FRONT, bil_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    status = bil_pkg::ST_EMPTY;
                end
            end
            bil_pkg::MODE_INSERT:
            begin
                if (is_full)
                begin
                    status = bil_pkg::ST_FULL;
                end
                else if (pos_cmp > len_cmp)
                begin
                    status = bil_pkg::ST_RANGE;
                end
            end
            bil_pkg::MODE_REMOVE, bil_pkg::MODE_READ:
            begin
                if (is_empty)
                begin
                    status = bil_pkg::ST_EMPTY;
                end
                else if (pos_cmp >= len_cmp)
                begin
                    status = bil_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status = bil_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            bil_pkg::RD_FRONT: rd_idx = '0;
            bil_pkg::RD_BACK:  rd_idx = back_idx;
            bil_pkg::RD_POS:   rd_idx = pos_idx;
            bil_pkg::RD_NEXT:  rd_idx = prev_reg + AW'(1);
            bil_pkg::RD_PRIOR: rd_idx = prev_reg - AW'(1);
            default:           rd_idx = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            bil_pkg::WR_LEN:   wr_idx = len_idx;
            bil_pkg::WR_POS:   wr_idx = pos_idx;
            bil_pkg::WR_NEXT:  wr_idx = prev_reg + AW'(1);
            bil_pkg::WR_PRIOR: wr_idx = prev_reg - AW'(1);
            default:           wr_idx = '0;
        endcase
    end

    assign rd_addr = phys_addr(head_reg, rd_idx);
    assign wr_addr = (cmd.wr_sel == bil_pkg::WR_HEAD_DEC) ? head_dec
                                                          : phys_addr(head_reg, wr_idx);
    assign wr_data = cmd.wr_ram ? ram_rdata : req_reg.value;

    bil_ram #(
        .WIDTH (bil_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // new head and length, applied when the result is loaded
    always_comb
    begin
        head_next   = head_reg;
        length_next = length_reg;
        if (status == bil_pkg::ST_OK)
        begin
            case (req_reg.mode) inside
                bil_pkg::MODE_PUSH_FRONT:
                begin
                    head_next   = head_dec;
                    length_next = length_reg + LEN_W'(1);
                end
                bil_pkg::MODE_PUSH_BACK, bil_pkg::MODE_INSERT:
                begin
                    length_next = length_reg + LEN_W'(1);
                end
                bil_pkg::MODE_POP_FRONT:
                begin
                    head_next   = head_inc;
                    length_next = len_dec;
                end
                bil_pkg::MODE_POP_BACK, bil_pkg::MODE_REMOVE:
                begin
                    length_next = len_dec;
                end
                bil_pkg::MODE_CLEAR:
                begin
                    length_next = '0;
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    assign new_len_cmp = CMP_W'(length_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            length_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                head_reg      <= head_next;
                length_reg    <= length_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg <= req;
        end
        if (cmd.rd_en)
        begin
            prev_reg <= rd_idx;
        end
        if (cmd.clr_data)
        begin
            data_reg <= '0;
        end
        else if (cmd.cap_data)
        begin
            data_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            rsp_reg.data   <= data_reg;
            rsp_reg.count  <= new_len_cmp[bil_pkg::CNT_W-1:0];
            rsp_reg.status <= status;
        end
    end

    assign stat.mode         = req_reg.mode;
    assign stat.err          = (status != bil_pkg::ST_OK);
    assign stat.pos_is_len   = (pos_cmp == len_cmp);
    assign stat.prev_is_pos  = (prev_reg == pos_idx);
    assign stat.prev_is_last = (prev_reg == back_idx);
    assign stat.out_free     = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BIL_ASSERT_IMP(a_no_rw_clash, cmd.rd_en && cmd.wr_en, rd_addr != wr_addr, "read and write hit one slot")
    `BIL_ASSERT_IMP(a_load_slot_free, cmd.finish, !rsp_valid_reg || rsp_ready, "result overwrites a waiting result")
    `BIL_ASSERT_NEXT(a_load_shows, cmd.finish, rsp_valid_reg, "loaded result not presented")
    `BIL_ASSERT_IMP(a_ram_only_ok, cmd.rd_en || cmd.wr_en, status == bil_pkg::ST_OK, "store accessed by a failing request")

endmodule

@@ src/bounded_indexed_list.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_list
// ordered list of up to DEPTH signed 32-bit values with push, pop, indexed
// insert, remove and read, and clear; one result item per request item
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake               payload
//  -------   ---   ---------------------   ----------------------------------
//  req       in    req_valid / req_ready   mode, position, value
//  rsp       out   rsp_valid / rsp_ready   data, count, status
//
// steps per item: push, clear or a failing request execute and finish; pop and
// read add a read step; remove at p and insert at p below length add a copy
// loop through the single write port of the store, so that one entry moves per
// cycle while the list closes or opens a gap
// reset clears head, length and the result register valid; the store is not
// cleared, only entries below length are ever read
// a new item is taken while a result still waits on rsp; that next result
// waits in the sequencer until the result register is free
//
module bounded_indexed_list #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bil_pkg::bil_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bil_pkg::bil_rsp_t rsp
);

    // commands from the sequencer, status back from the datapath
    bil_pkg::bil_cmd_t  cmd;
    bil_pkg::bil_stat_t stat;

    // sequencer: one request at a time, steps the copy loop for insert/remove
    bil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: circular store addressed from a head pointer, so pushes and
    // pops at the front need no shifting; status is checked before any access
    bil_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ test/bounded_indexed_list_checker.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_list_checker
// watches both channels of the list block, keeps a shadow copy of the list,
// works out the reply to every accepted request item and compares each
// accepted reply item with the oldest outstanding one, field by field
// ----------------------------------------------------------------------------
module bounded_indexed_list_checker #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  bil_pkg::bil_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  bil_pkg::bil_rsp_t rsp,
    output int                mismatches,
    output int                waiting
);
    import bil_pkg::*;

    logic signed [DATA_W-1:0] shadow_vals [DEPTH];
    int unsigned              shadow_len;
    bil_rsp_t                 outstanding_replies [$];
    int unsigned              replies_seen;

    task automatic report_mismatch(input string what);
        $display("mismatch at reply %0d: %s", replies_seen, what);
        mismatches++;
    endtask

    // open a gap at slot p and drop v into it
    function automatic void open_slot(input int unsigned p, input logic signed [DATA_W-1:0] v);
        for (int unsigned i = shadow_len; i > p; i--)
            shadow_vals[i] = shadow_vals[i - 1];
        shadow_vals[p] = v;
        shadow_len++;
    endfunction

    // pull the value out of slot p and close the gap
    function automatic logic signed [DATA_W-1:0] close_slot(input int unsigned p);
        logic signed [DATA_W-1:0] v;
        v = shadow_vals[p];
        for (int unsigned i = p; i + 1 < shadow_len; i++)
            shadow_vals[i] = shadow_vals[i + 1];
        shadow_len--;
        return v;
    endfunction

    // apply one request to the shadow list and return the reply it causes
    function automatic bil_rsp_t predict_reply(input bil_req_t r);
        bil_rsp_t    o;
        int unsigned p;
        o.data   = '0;
        o.status = ST_OK;
        p        = r.position;
        case (r.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
                if (shadow_len >= DEPTH)
                    o.status = ST_FULL;
                else
                    open_slot(r.mode == MODE_PUSH_FRONT ? 0 : shadow_len, r.value);
            MODE_POP_FRONT, MODE_POP_BACK:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else
                    o.data = close_slot(r.mode == MODE_POP_FRONT ? 0 : shadow_len - 1);
            MODE_INSERT:
                if (shadow_len >= DEPTH)
                    o.status = ST_FULL;
                else if (p > shadow_len)
                    o.status = ST_RANGE;
                else
                    open_slot(p, r.value);
            MODE_REMOVE, MODE_READ:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else if (p >= shadow_len)
                    o.status = ST_RANGE;
                else if (r.mode == MODE_REMOVE)
                    o.data = close_slot(p);
                else
                    o.data = shadow_vals[p];
            MODE_CLEAR:
                shadow_len = 0;
            default:
                o.status = ST_OK;
        endcase
        o.count = CNT_W'(shadow_len);
        return o;
    endfunction

    always @(posedge clk)
    begin
        bil_rsp_t want;
        if (!rst_n)
        begin
            outstanding_replies.delete();
            shadow_len   = 0;
            mismatches   = 0;
            replies_seen = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                replies_seen++;
                if (outstanding_replies.size() == 0)
                    report_mismatch("reply item with no request outstanding");
                else
                begin
                    want = outstanding_replies.pop_front();
                    if (rsp.data !== want.data)
                        report_mismatch($sformatf("data %0d, want %0d", rsp.data, want.data));
                    if (rsp.count !== want.count)
                        report_mismatch($sformatf("count %0d, want %0d", rsp.count, want.count));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp.status, want.status));
                end
            end
            if (req_valid && req_ready)
                outstanding_replies.push_back(predict_reply(req));
        end
        waiting = outstanding_replies.size();
    end

endmodule

@@ test/bounded_indexed_list_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_list_tb
// drives request items into the list block, a directed opening and then
// random sequences that grow, shrink and churn the list, under several
// sender and receiver idling mixes; the checker beside the block does the
// comparing, this top only makes stimulus and calls the verdict
// ----------------------------------------------------------------------------
module bounded_indexed_list_tb;
    import bil_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 4;
    // limit covers the longest items plus sender gaps and receiver stalls
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;

    // how a random episode leans
    typedef enum int {
        LEAN_GROW,
        LEAN_SHRINK,
        LEAN_MIXED
    } lean_t;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bil_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bil_rsp_t rsp;

    int       mismatches;
    int       waiting;

    // idling mix, in cycles out of a hundred
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    // long receiver hold-off, picked up by the receiver process
    bit          hold_go   = 1'b0;
    int unsigned hold_left = 0;
    // length of the list as the stimulus sees it, used only to aim positions
    int          est_len   = 0;
    int unsigned cycle_count = 0;

    bounded_indexed_list #(
        .DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bounded_indexed_list_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit: a hang anywhere ends here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked for one
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_left = HOLD_CYCLES;
                hold_go   = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic bil_req_t make_request(input bil_mode_t m, input int p,
                                              input logic signed [DATA_W-1:0] v);
        bil_req_t r;
        r.mode     = m;
        r.position = POS_W'(p);
        r.value    = v;
        return r;
    endfunction

    // extremes now and then, otherwise any 32-bit pattern
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // hi is the highest position that succeeds, below zero when none does
    function automatic logic [POS_W-1:0] pick_pos(input int hi);
        int unsigned r;
        r = $urandom_range(99);
        if (hi < 0 || (r < 12 && hi < 32))
            return POS_W'($urandom_range(32, hi + 1));
        if (r < 27)
            return POS_W'(hi);
        if (r < 37)
            return '0;
        return POS_W'($urandom_range(hi, 0));
    endfunction

    function automatic bil_mode_t pick_mode(input lean_t lean);
        int unsigned w [8];
        int unsigned r;
        int unsigned acc;
        // push front, push back, pop front, pop back, insert, remove, read, clear
        case (lean)
            LEAN_GROW:   w = '{20, 20, 2, 2, 40, 3, 13, 0};
            LEAN_SHRINK: w = '{5, 5, 20, 20, 5, 30, 15, 0};
            default:     w = '{12, 12, 12, 12, 14, 14, 22, 2};
        endcase
        r   = $urandom_range(99);
        acc = 0;
        for (int i = 0; i < 8; i++)
        begin
            acc += w[i];
            if (r < acc)
                return bil_mode_t'(i);
        end
        return MODE_READ;
    endfunction

    function automatic bil_req_t pick_item(input lean_t lean);
        bil_req_t r;
        r.mode  = pick_mode(lean);
        r.value = pick_value();
        if ($urandom_range(99) < 8)
        begin
            // noise: any mode at any position from 0 to 32
            r.mode     = bil_mode_t'($urandom_range(7));
            r.position = POS_W'($urandom_range(32));
        end
        else
            case (r.mode)
                MODE_INSERT:            r.position = pick_pos(est_len);
                MODE_REMOVE, MODE_READ: r.position = pick_pos(est_len - 1);
                default:                r.position = POS_W'($urandom_range(32));
            endcase
        return r;
    endfunction

    // offer one item; called and returning at a rising edge, the accept edge
    task automatic send_item(input bil_req_t item);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        // ready seen mid-cycle means the item goes at the next rising edge
        @(negedge clk);
        while (!req_ready)
            @(negedge clk);
        @(posedge clk);
        case (item.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
                if (est_len < DEPTH)
                    est_len++;
            MODE_INSERT:
                if (est_len < DEPTH && item.position <= est_len)
                    est_len++;
            MODE_POP_FRONT, MODE_POP_BACK:
                if (est_len > 0)
                    est_len--;
            MODE_REMOVE:
                if (est_len > 0 && item.position < est_len)
                    est_len--;
            MODE_CLEAR:
                est_len = 0;
            default:
                est_len = est_len;
        endcase
    endtask

    initial
    begin
        bil_req_t    directed [$];
        int unsigned gap_by_phase [PHASES];
        int unsigned stall_by_phase [PHASES];
        int unsigned sent;
        int unsigned run;
        lean_t       lean;

        gap_by_phase   = '{0, 84, 0, 31};
        stall_by_phase = '{0, 0, 84, 31};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, no idling
        // every take on an empty list
        directed.push_back(make_request(MODE_POP_FRONT, 0, 32'sd7));
        directed.push_back(make_request(MODE_POP_BACK, 0, 32'sd7));
        directed.push_back(make_request(MODE_REMOVE, 0, 32'sd7));
        directed.push_back(make_request(MODE_READ, 0, 32'sd7));
        // insert past the end of an empty list
        directed.push_back(make_request(MODE_INSERT, 1, 32'sd9));
        // fill with extremes from both ends, at the end and at the head
        directed.push_back(make_request(MODE_PUSH_FRONT, 0, 32'sh8000_0000));
        directed.push_back(make_request(MODE_PUSH_BACK, 0, 32'sh7fff_ffff));
        directed.push_back(make_request(MODE_INSERT, 2, 32'sd0));
        directed.push_back(make_request(MODE_INSERT, 0, -32'sd1));
        // insert just past the end and at the top position
        directed.push_back(make_request(MODE_INSERT, 5, 32'sd11));
        directed.push_back(make_request(MODE_INSERT, 32, 32'sd11));
        // read the last entry, then just past it and far past it
        directed.push_back(make_request(MODE_READ, 3, 32'sd0));
        directed.push_back(make_request(MODE_READ, 4, 32'sd0));
        directed.push_back(make_request(MODE_READ, 32, 32'sd0));
        // remove from the middle, then one past the end
        directed.push_back(make_request(MODE_REMOVE, 1, 32'sd0));
        directed.push_back(make_request(MODE_REMOVE, 3, 32'sd0));
        directed.push_back(make_request(MODE_POP_FRONT, 0, 32'sd0));
        directed.push_back(make_request(MODE_POP_BACK, 0, 32'sd0));
        // clear a non-empty list, read it, clear it again empty
        directed.push_back(make_request(MODE_CLEAR, 0, 32'sd0));
        directed.push_back(make_request(MODE_READ, 0, 32'sd0));
        directed.push_back(make_request(MODE_CLEAR, 0, 32'sd0));
        // insert at the end of an empty list succeeds
        directed.push_back(make_request(MODE_INSERT, 0, 32'sh5555_5555));
        directed.push_back(make_request(MODE_REMOVE, 0, 32'sd0));
        foreach (directed[i])
            send_item(directed[i]);

        // random part: episodes that lean toward growth, shrinkage or churn,
        // so the list runs into full and empty again and again
        for (int ph = 0; ph < PHASES; ph++)
        begin
            gap_pct   = gap_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            // long hold-off with the sender flat out: the block must back up
            if (ph == 0)
                hold_go = 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
            begin
                run  = $urandom_range(50, 20);
                lean = (sent == 0) ? LEAN_GROW : lean_t'($urandom_range(2));
                for (int k = 0; k < run; k++)
                    send_item(pick_item(lean));
                sent += run;
            end
        end
        req_valid <= 1'b0;

        // wait for every reply, then give stray items time to show up
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
